[rtl/nbg_pkg.sv]
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared types, constants and helpers of the N-body gravity step unit.
// ----------------------------------------------------------------------------
package nbg_pkg;

	localparam int MAX_BODIES = 16;
	localparam int BODY_W     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CNT_W      = $clog2(MAX_BODIES + 1);
	localparam int ACC_W      = 32 + $clog2(MAX_BODIES);

	localparam int IDX_W      = 4;
	localparam int DT_W       = 32;
	localparam int NB_W       = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 232;
	localparam int OUT_DATA_W = 200;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int DIV_W       = 96;
	localparam int DIV_STEPS   = 96;
	localparam int SQRT_STEPS  = 32;
	localparam int STEP_CNT_W  = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_INCREMENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BODIES_IN_USE  = 1'b1;
	localparam logic [DT_W-1:0]      DT_RESET           = 32'h0001_0000;
	localparam logic [NB_W-1:0]      NB_RESET           = 5'd16;

	localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0] vec3_t;

	typedef struct packed {
		logic [31:0] gm;
		vec3_t       pos;
		vec3_t       vel;
	} body_t;

	localparam int BODY_BITS = $bits(body_t);

	typedef struct packed {
		logic             is_step;
		logic             load_ok;
		logic [IDX_W-1:0] index;
		body_t            body;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] gm;
		vec3_t       pos_i;
		vec3_t       pos_j;
	} pair_req_t;

	typedef struct packed {
		logic  done;
		logic  fault;
		vec3_t term;
	} pair_rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		vec3_t            pos;
		vec3_t            vel;
		logic             fault;
		logic             last;
	} out_t;

	typedef enum logic [3:0] {
		P_IDLE, P_SQ, P_SQRT, P_D2, P_PROD, P_DIV1, P_MID, P_DIV2, P_TERM, P_FIN
	} pair_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_RD_I, B_LAT_I, B_NEXT_J, B_LAT_J, B_WAIT_P,
		B_U1, B_U2, B_U3, B_U4, B_U5
	} back_state_t;

	function automatic logic signed [63:0] sx32(input word_t x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic sat_hit(input logic signed [63:0] v);
		return (v > WORD_MAX) || (v < WORD_MIN);
	endfunction

	function automatic word_t sat_word(input logic signed [63:0] v);
		if (v > WORD_MAX) begin
			return 32'sh7fff_ffff;
		end else if (v < WORD_MIN) begin
			return 32'sh8000_0000;
		end
		return word_t'(v[31:0]);
	endfunction

endpackage

[rtl/nbg_ram.sv]
// ----------------------------------------------------------------------------
// nbg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/nbg_front.sv]
// ----------------------------------------------------------------------------
// nbg_front
// Input side: takes items, decodes load or step, and queues them.
// ----------------------------------------------------------------------------
module nbg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [nbg_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           head_valid,
	output nbg_pkg::item_t                 head,
	input  logic                           pop
);
	import nbg_pkg::*;

	item_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	item_t                 item_in;
	logic                  push;

	always_comb begin
		item_in.is_step  = s_tuser;
		item_in.index    = s_tdata[3:0];
		item_in.load_ok  = int'(s_tdata[3:0]) < MAX_BODIES;
		item_in.body.gm  = s_tdata[35:4];
		item_in.body.pos = s_tdata[131:36];
		item_in.body.vel = s_tdata[227:132];
	end

	assign s_tready   = count_q < FIFO_CNT_W'(FIFO_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign head_valid = count_q != '0;
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/nbg_pair.sv]
// ----------------------------------------------------------------------------
// nbg_pair
// Pair force unit: gm_j * R / |R|^3 per axis with a bit-serial square root
// and a shared restoring divider.
// ----------------------------------------------------------------------------
module nbg_pair (
	input  logic               clk,
	input  logic               arst_n,
	input  nbg_pkg::pair_req_t req,
	output nbg_pkg::pair_rsp_t rsp
);
	import nbg_pkg::*;

	pair_state_t            state_q, state_d;
	logic [31:0]            gm_q;
	logic [2:0]             neg_q;
	logic [30:0]            ush_q [3];
	logic [1:0]             s_q;
	logic [1:0]             c_q;
	logic [63:0]            x_q, res_q, bit_q, d2_q;
	logic [DIV_W-1:0]       dvd_q;
	logic [63:0]            rem_q, dsr_q;
	logic [STEP_CNT_W-1:0]  cnt_q;
	logic                   fault_q;
	vec3_t                  term_q;

	logic signed [32:0] r [3];
	logic [32:0]        u [3];
	logic [30:0]        ush_d [3];
	logic [1:0]         s_d;
	logic               coincident;
	logic [61:0]        sq;
	logic [63:0]        sq_t;
	logic               sq_ge;
	logic [64:0]        rem_sh, rem_sub;
	logic               div_ge;
	logic [63:0]        prod;
	logic [DIV_W-1:0]   qsh;
	logic [30:0]        mag;
	logic               big;
	word_t              tval;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			r[c] = {req.pos_j[c][31], req.pos_j[c]} - {req.pos_i[c][31], req.pos_i[c]};
			u[c] = r[c][32] ? unsigned'(-r[c]) : unsigned'(r[c]);
		end
		if (u[0][32] || u[1][32] || u[2][32]) begin
			s_d = 2'd2;
		end else if (u[0][31] || u[1][31] || u[2][31]) begin
			s_d = 2'd1;
		end else begin
			s_d = 2'd0;
		end
		for (int c = 0; c < 3; c++) begin
			ush_d[c] = 31'(u[c] >> s_d);
		end
		coincident = (r[0] == '0) && (r[1] == '0) && (r[2] == '0);
	end

	always_comb begin
		sq      = 62'(64'(ush_q[c_q]) * 64'(ush_q[c_q]));
		sq_t    = res_q + bit_q;
		sq_ge   = x_q >= sq_t;
		rem_sh  = {rem_q, dvd_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		div_ge  = rem_sh >= {1'b0, dsr_q};
		prod    = 64'(gm_q) * 64'(ush_q[c_q]);
		qsh     = dvd_q >> {s_q, 1'b0};
		big     = |qsh[DIV_W-1:31];
		mag     = big ? '1 : qsh[30:0];
		tval    = neg_q[c_q] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
	end

	always_comb begin
		state_d  = state_q;
		rsp.done = 1'b0;
		unique case (state_q)
			P_IDLE: if (req.start) state_d = coincident ? P_FIN : P_SQ;
			P_SQ:   if (c_q == 2'd2) state_d = P_SQRT;
			P_SQRT: if (int'(cnt_q) == SQRT_STEPS - 1) state_d = P_D2;
			P_D2:   state_d = P_PROD;
			P_PROD: state_d = P_DIV1;
			P_DIV1: if (int'(cnt_q) == DIV_STEPS - 1) state_d = P_MID;
			P_MID:  state_d = P_DIV2;
			P_DIV2: if (int'(cnt_q) == DIV_STEPS - 1) state_d = P_TERM;
			P_TERM: state_d = (c_q == 2'd2) ? P_FIN : P_PROD;
			P_FIN: begin
				rsp.done = 1'b1;
				state_d  = P_IDLE;
			end
			default: state_d = P_IDLE;
		endcase
	end

	assign rsp.fault = fault_q;
	assign rsp.term  = term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			P_IDLE: begin
				gm_q    <= req.gm;
				s_q     <= s_d;
				c_q     <= '0;
				x_q     <= '0;
				fault_q <= coincident;
				term_q  <= '0;
				for (int c = 0; c < 3; c++) begin
					ush_q[c] <= ush_d[c];
					neg_q[c] <= r[c][32];
				end
			end
			P_SQ: begin
				x_q   <= x_q + 64'(sq);
				c_q   <= c_q + 1'b1;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				cnt_q <= '0;
			end
			P_SQRT: begin
				if (sq_ge) begin
					x_q   <= x_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
			end
			P_D2: begin
				d2_q <= 64'(res_q[31:0]) * 64'(res_q[31:0]);
				c_q  <= '0;
			end
			P_PROD: begin
				dvd_q <= {1'b0, prod[62:0], 32'b0};
				rem_q <= '0;
				dsr_q <= d2_q;
				cnt_q <= '0;
			end
			P_DIV1, P_DIV2: begin
				rem_q <= div_ge ? rem_sub[63:0] : rem_sh[63:0];
				dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			P_MID: begin
				rem_q <= '0;
				dsr_q <= {32'b0, res_q[31:0]};
				cnt_q <= '0;
			end
			P_TERM: begin
				term_q[c_q] <= tval;
				if (big) begin
					fault_q <= 1'b1;
				end
				c_q <= c_q + 1'b1;
			end
			P_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == P_IDLE)
		else $error("pair unit started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("pair unit done twice in a row");

endmodule

[rtl/nbg_back.sv]
// ----------------------------------------------------------------------------
// nbg_back
// Execution side: body store, load writes, the per-body step sequence and
// the result register.
// ----------------------------------------------------------------------------
module nbg_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  nbg_pkg::item_t            head,
	output logic                      pop,
	input  logic [nbg_pkg::DT_W-1:0]  dt,
	input  logic [nbg_pkg::NB_W-1:0]  nb,
	output logic                      out_valid,
	input  logic                      out_ready,
	output nbg_pkg::out_t             out
);
	import nbg_pkg::*;

	back_state_t               state_q, state_d;
	logic [BODY_W-1:0]         i_q;
	logic [CNT_W-1:0]          j_q, n_q;
	logic [31:0]               gm_i_q;
	vec3_t                     pos_i_q, vel_i_q, a_q, vn_q;
	logic signed [ACC_W-1:0]   acc_q [3];
	logic [47:0]               pa_q [3];
	logic [2:0]                pneg_q;
	logic                      flag_q;
	logic                      out_valid_q;
	out_t                      out_q;

	logic                      out_free;
	logic [CNT_W-1:0]          n_d;
	logic                      ram_we;
	logic [BODY_W-1:0]         ram_waddr, ram_raddr;
	body_t                     ram_wdata, ram_rdata;
	pair_req_t                 req;
	pair_rsp_t                 rsp;
	logic [63:0]               mul [3];
	logic signed [63:0]        sum [3];
	vec3_t                     pn;
	logic                      pn_hit;
	logic                      last_body;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out       = out_q;
	assign n_d       = (int'(nb) < MAX_BODIES) ? CNT_W'(nb) : CNT_W'(MAX_BODIES);
	assign last_body = CNT_W'(i_q) == n_q - CNT_W'(1);

	nbg_ram #(.WIDTH(BODY_BITS), .DEPTH(MAX_BODIES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.start = state_q == B_LAT_J;
	assign req.gm    = ram_rdata.gm;
	assign req.pos_i = pos_i_q;
	assign req.pos_j = ram_rdata.pos;

	nbg_pair u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// lane datapath: |x| * dt >> 16 and the signed saturating adds
	always_comb begin
		logic [32:0] mag;
		logic signed [63:0] ext;
		pn_hit = 1'b0;
		for (int c = 0; c < 3; c++) begin
			if (state_q == B_U2) begin
				mag = a_q[c][31] ? unsigned'(-{a_q[c][31], a_q[c]}) : {1'b0, a_q[c]};
			end else begin
				mag = vn_q[c][31] ? unsigned'(-{vn_q[c][31], vn_q[c]}) : {1'b0, vn_q[c]};
			end
			mul[c] = 64'(mag[31:0]) * 64'(dt);
			ext    = signed'({16'b0, pa_q[c]});
			if (state_q == B_U3) begin
				sum[c] = sx32(vel_i_q[c]) + (pneg_q[c] ? -ext : ext);
			end else begin
				sum[c] = sx32(pos_i_q[c]) + (pneg_q[c] ? -ext : ext);
			end
			pn[c]  = sat_word(sum[c]);
			pn_hit = pn_hit | sat_hit(sum[c]);
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = '{gm: gm_i_q, pos: pn, vel: vn_q};
		ram_raddr = (state_q == B_RD_I) ? i_q : j_q[BODY_W-1:0];
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					if (!head.is_step) begin
						ram_we    = head.load_ok;
						ram_waddr = BODY_W'(head.index);
						ram_wdata = head.body;
					end else if (n_d != '0) begin
						state_d = B_RD_I;
					end
				end
			end
			B_RD_I:  state_d = B_LAT_I;
			B_LAT_I: state_d = B_NEXT_J;
			B_NEXT_J: begin
				if (j_q == n_q) begin
					state_d = B_U1;
				end else if (j_q != CNT_W'(i_q)) begin
					state_d = B_LAT_J;
				end
			end
			B_LAT_J: state_d = B_WAIT_P;
			B_WAIT_P: if (rsp.done) state_d = B_NEXT_J;
			B_U1: state_d = B_U2;
			B_U2: state_d = B_U3;
			B_U3: state_d = B_U4;
			B_U4: state_d = B_U5;
			B_U5: begin
				if (out_free) begin
					ram_we  = 1'b1;
					state_d = last_body ? B_IDLE : B_RD_I;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_U5 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				n_q <= n_d;
				i_q <= '0;
			end
			B_RD_I: begin
			end
			B_LAT_I: begin
				gm_i_q  <= ram_rdata.gm;
				pos_i_q <= ram_rdata.pos;
				vel_i_q <= ram_rdata.vel;
				flag_q  <= 1'b0;
				j_q     <= '0;
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= '0;
				end
			end
			B_NEXT_J: begin
				if (j_q != n_q && j_q == CNT_W'(i_q)) begin
					j_q <= j_q + 1'b1;
				end
			end
			B_LAT_J: begin
			end
			B_WAIT_P: begin
				if (rsp.done) begin
					for (int c = 0; c < 3; c++) begin
						acc_q[c] <= acc_q[c] + {{(ACC_W-32){rsp.term[c][31]}}, rsp.term[c]};
					end
					flag_q <= flag_q | rsp.fault;
					j_q    <= j_q + 1'b1;
				end
			end
			B_U1: begin
				for (int c = 0; c < 3; c++) begin
					a_q[c] <= sat_word({{(64-ACC_W){acc_q[c][ACC_W-1]}}, acc_q[c]});
					if (sat_hit({{(64-ACC_W){acc_q[c][ACC_W-1]}}, acc_q[c]})) begin
						flag_q <= 1'b1;
					end
				end
			end
			B_U2: begin
				for (int c = 0; c < 3; c++) begin
					pa_q[c]   <= mul[c][63:16];
					pneg_q[c] <= a_q[c][31];
				end
			end
			B_U3: begin
				for (int c = 0; c < 3; c++) begin
					vn_q[c] <= sat_word(sum[c]);
					if (sat_hit(sum[c])) begin
						flag_q <= 1'b1;
					end
				end
			end
			B_U4: begin
				for (int c = 0; c < 3; c++) begin
					pa_q[c]   <= mul[c][63:16];
					pneg_q[c] <= vn_q[c][31];
				end
			end
			B_U5: begin
				if (out_free) begin
					out_q.index <= IDX_W'(i_q);
					out_q.pos   <= pn;
					out_q.vel   <= vn_q;
					out_q.fault <= flag_q | pn_hit;
					out_q.last  <= last_body;
					i_q         <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && state_q == B_IDLE)
		else $error("queue popped while empty or busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == B_WAIT_P)
		else $error("pair result arrived while not waiting");

endmodule

[rtl/n_body_gravity_step_unit.sv]
// ----------------------------------------------------------------------------
// n_body_gravity_step_unit
// Direct-summation gravitational N-body step, semi-implicit Euler, Q16.16.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one body into the store. A step item (tuser 1)
// updates bodies 0 .. n-1 in order, n being bodies_in_use capped at the store
// size, and returns one result per body, tlast on the final one. Each pair
// interaction runs through one shared force unit: a square root and, per axis,
// two restoring divisions. Two items can queue ahead of the core, and a
// finished result waits in an output register without blocking the input side.
module n_body_gravity_step_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// body_index, grav_mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic [nbg_pkg::IN_DATA_W-1:0]      s_tdata,
	// kind
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_index, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [nbg_pkg::OUT_DATA_W-1:0]     m_tdata,
	// fault
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [nbg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nbg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import nbg_pkg::*;

	logic [DT_W-1:0] dt_q;
	logic [NB_W-1:0] nb_q;
	logic            head_valid, pop;
	item_t           head;
	out_t            out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
			nb_q <= NB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIME_INCREMENT: dt_q <= cfg_data[DT_W-1:0];
				CFG_BODIES_IN_USE:  nb_q <= cfg_data[NB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nbg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	nbg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dt         (dt_q),
		.nb         (nb_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out        (out)
	);

	assign m_tdata = {4'b0, out.vel, out.pos, out.index};
	assign m_tuser = out.fault;
	assign m_tlast = out.last;

endmodule
